/* rtl/hfr_pkg.sv */
// ----------------------------------------------------------------------------
// hfr_pkg
// Shared types and constants of the hunting frame receiver.
// ----------------------------------------------------------------------------
package hfr_pkg;

	localparam int CANDIDATE_SLOTS = 4;
	localparam int MAX_FRAME_LEN   = 32;
	localparam int PAYLOAD_CAP     = MAX_FRAME_LEN - 4;
	localparam int SLOT_W          = $clog2(CANDIDATE_SLOTS);
	localparam int AGE_W           = (SLOT_W > 0) ? SLOT_W : 1;
	localparam int PIDX_W          = $clog2(PAYLOAD_CAP);
	localparam int PAYLOAD_DEPTH   = CANDIDATE_SLOTS * PAYLOAD_CAP;
	localparam int PADDR_W         = $clog2(PAYLOAD_DEPTH);

	localparam logic [7:0] START_BYTE   = 8'h02;
	localparam logic [7:0] HEADER_BYTES = 8'd5;
	localparam logic [5:0] LIMIT_RESET  = 6'd32;
	localparam logic [0:0] REG_LENGTH_LIMIT = 1'b0;

	typedef struct packed {
		logic        active;
		logic [7:0]  position;
		logic [7:0]  check;
		logic [15:0] address;
		logic [7:0]  length;
		logic [7:0]  command;
		logic [AGE_W-1:0] age;
	} slot_t;

	// Byte broadcast that travels along the row of cells.
	typedef struct packed {
		logic       valid;
		logic [7:0] data;
		logic [7:0] limit;
	} beat_t;

	// What one cell reports after it has seen a beat.
	typedef struct packed {
		logic       win;
		logic       drop;
		logic       store;
		logic [PIDX_W-1:0] store_idx;
	} cell_rpt_t;

	typedef enum logic [1:0] {
		ST_HUNT,
		ST_WAIT,
		ST_SEND
	} state_t;

endpackage

/* rtl/hfr_if.sv */
// ----------------------------------------------------------------------------
// hfr_byte_if / hfr_frame_if
// Valid/ready channels for received bytes and for result items.
// ----------------------------------------------------------------------------
interface hfr_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface hfr_frame_if;
	logic        valid;
	logic        ready;
	logic [15:0] frame_address;
	logic [7:0]  frame_command;
	logic [5:0]  frame_length;
	logic [7:0]  payload_byte;
	logic [4:0]  payload_index;
	logic        has_payload;
	logic        slot_overflow;
	logic        last;
	modport source (output valid, output frame_address, output frame_command,
		output frame_length, output payload_byte, output payload_index,
		output has_payload, output slot_overflow, output last, input ready);
	modport sink (input valid, input frame_address, input frame_command,
		input frame_length, input payload_byte, input payload_index,
		input has_payload, input slot_overflow, input last, output ready);
endinterface

/* rtl/hfr_ram.sv */
// ----------------------------------------------------------------------------
// hfr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* rtl/hfr_cell.sv */
// ----------------------------------------------------------------------------
// hfr_cell
// One candidate slot: tracks position, check, header fields and age, and
// passes the byte beat on to its neighbor in the next cycle.
// ----------------------------------------------------------------------------
module hfr_cell import hfr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  beat_t            beat_in,
	input  logic             open,
	input  logic             clear_all,
	input  logic             age_inc,
	input  logic [AGE_W-1:0] drop_age,
	input  logic             drop_any,
	output beat_t            beat_out,
	output slot_t            slot,
	output cell_rpt_t        rpt
);
	slot_t slot_q;
	slot_t slot_d;
	beat_t beat_q;
	logic  at_check;
	logic  bad_len;
	logic [7:0] p;
	logic [7:0] b;

	assign p        = slot_q.position;
	assign b        = beat_in.data;
	assign at_check = (p >= HEADER_BYTES) && (p == slot_q.length);
	assign bad_len  = (b < HEADER_BYTES) || (b > beat_in.limit);

	always_comb begin
		rpt = '0;
		if (beat_in.valid && slot_q.active) begin
			if (at_check) begin
				rpt.win  = (slot_q.check == b);
				rpt.drop = (slot_q.check != b);
			end else if (p == 8'd3) begin
				rpt.drop = bad_len;
			end else if (p >= HEADER_BYTES && (p - HEADER_BYTES) < 8'(PAYLOAD_CAP)) begin
				rpt.store     = 1'b1;
				rpt.store_idx = PIDX_W'(p - HEADER_BYTES);
			end
		end
	end

	always_comb begin
		slot_d = slot_q;
		if (clear_all) begin
			slot_d.active = 1'b0;
			slot_d.age    = '0;
		end else if (open) begin
			slot_d        = '0;
			slot_d.active = 1'b1;
		end else begin
			if (slot_q.active && drop_any && slot_q.age > drop_age) begin
				slot_d.age = slot_q.age - 1'b1;
			end else if (slot_q.active && age_inc) begin
				slot_d.age = slot_q.age + 1'b1;
			end
			if (beat_in.valid && slot_q.active) begin
				if (rpt.drop) begin
					slot_d.active = 1'b0;
					slot_d.age    = '0;
				end else if (!at_check) begin
					slot_d.check    = (slot_q.check ^ b) + 8'd1;
					slot_d.position = p + 8'd1;
					case (p)
						8'd1: slot_d.address = {8'h00, b};
						8'd2: slot_d.address[15:8] = b;
						8'd3: slot_d.length = b;
						8'd4: slot_d.command = b;
						default: ;
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			beat_q <= '0;
		end else begin
			beat_q <= beat_in;
			slot_q <= slot_d;
		end
	end

	assign beat_out = beat_q;
	assign slot     = slot_q;
endmodule

/* rtl/hunting_frame_receiver_unit.sv */
// ----------------------------------------------------------------------------
// hunting_frame_receiver_unit
// Hunts for framed packets in a byte stream with several candidate slots.
// ----------------------------------------------------------------------------
// Each item is one received byte. A byte passes down a row of slot cells,
// one cell per cycle: it is taken in the hunt state, then the wait state
// opens a slot, visits each cell in turn and settles, and the hunt state
// returns when no frame completes. On an accepted frame the header and
// payload go out as one result item per payload byte, or one for an empty
// payload, one per cycle while the receiver is ready, from the payload RAM
// read port; the next byte is taken in the cycle after the last result item
// is delivered.
module hunting_frame_receiver_unit import hfr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	hfr_byte_if.sink    rx,
	hfr_frame_if.source frame,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [0:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam int CNT_W = $clog2(CANDIDATE_SLOTS + 2);

	state_t state_q, state_d;
	logic [5:0]       limit_q;
	logic [7:0]       byte_q;
	logic [CNT_W-1:0] step_q;
	logic             ovf_q;
	logic             win_q;
	logic [SLOT_W-1:0] win_slot_q;
	logic [AGE_W-1:0] win_age_q;
	logic [PIDX_W:0]  n_q, i_q;
	logic             cell_active_step;

	beat_t     beat [CANDIDATE_SLOTS+1];
	slot_t     slots [CANDIDATE_SLOTS];
	cell_rpt_t rpts [CANDIDATE_SLOTS];
	logic [CANDIDATE_SLOTS-1:0] open_v;
	logic      clear_all;
	logic      open_phase;
	logic      age_inc;
	logic      drop_any;
	logic [AGE_W-1:0] drop_age;
	logic [SLOT_W-1:0] cur;
	logic      accept_in;
	logic      out_fire;
	logic [7:0] lim_eff;

	assign pready = 1'b1;
	assign prdata = {26'd0, limit_q};
	assign accept_in = rx.valid && rx.ready;
	assign out_fire  = frame.valid && frame.ready;
	assign lim_eff   = (limit_q > 6'(MAX_FRAME_LEN)) ? 8'(MAX_FRAME_LEN) : {2'b00, limit_q};

	// Step 0 opens a slot; steps 1..N visit cells 0..N-1 in turn.
	assign open_phase = (state_q == ST_WAIT) && (step_q == '0);
	assign cell_active_step = (state_q == ST_WAIT) && (step_q != '0) &&
		(step_q <= CNT_W'(CANDIDATE_SLOTS));
	assign cur = SLOT_W'(step_q - 1'b1);

	// The byte enters the row at cell 0 during step 1 and moves one cell a cycle.
	assign beat[0] = '{valid: (state_q == ST_WAIT) && (step_q == CNT_W'(1)),
		data: byte_q, limit: lim_eff};

	always_comb begin
		logic found;
		logic [SLOT_W-1:0] pick;
		found = 1'b0;
		pick  = '0;
		open_v = '0;
		for (int k = 0; k < CANDIDATE_SLOTS; k++) begin
			if (!found && !slots[k].active) begin
				found = 1'b1;
				pick  = SLOT_W'(k);
			end
		end
		if (!found) begin
			for (int k = 0; k < CANDIDATE_SLOTS; k++) begin
				if (slots[k].age == AGE_W'(CANDIDATE_SLOTS - 1)) begin
					pick = SLOT_W'(k);
				end
			end
		end
		if (open_phase && byte_q == START_BYTE) begin
			open_v[pick] = 1'b1;
		end
		age_inc = open_phase && byte_q == START_BYTE;
		drop_any = 1'b0;
		drop_age = '0;
		if (age_inc && !found) begin
			drop_any = 1'b1;
			drop_age = slots[pick].age;
		end else if (cell_active_step && rpts[cur].drop) begin
			drop_any = 1'b1;
			drop_age = slots[cur].age;
		end
	end

	assign clear_all = (state_q == ST_SEND) && out_fire && frame.last;

	for (genvar g = 0; g < CANDIDATE_SLOTS; g++) begin : g_cell
		hfr_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.beat_in   (beat[g]),
			.open      (open_v[g]),
			.clear_all (clear_all),
			.age_inc   (age_inc),
			.drop_age  (drop_age),
			.drop_any  (drop_any && !(cell_active_step && cur == SLOT_W'(g) && !age_inc)),
			.beat_out  (beat[g+1]),
			.slot      (slots[g]),
			.rpt       (rpts[g])
		);
	end

	logic             ram_we;
	logic [PADDR_W-1:0] ram_waddr, ram_raddr;
	logic [7:0]       ram_rdata;

	assign ram_we    = cell_active_step && rpts[cur].store;
	assign ram_waddr = PADDR_W'(cur * PAYLOAD_CAP + rpts[cur].store_idx);
	assign ram_raddr = PADDR_W'(win_slot_q * PAYLOAD_CAP +
		((state_q == ST_SEND && out_fire) ? i_q + 1'b1 : i_q));

	hfr_ram #(.WIDTH(8), .DEPTH(PAYLOAD_DEPTH)) u_payload (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (byte_q),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_HUNT: if (accept_in) state_d = ST_WAIT;
			ST_WAIT: if (step_q == CNT_W'(CANDIDATE_SLOTS + 1)) begin
				state_d = win_q ? ST_SEND : ST_HUNT;
			end
			ST_SEND: if (out_fire && frame.last) state_d = ST_HUNT;
			default: state_d = ST_HUNT;
		endcase
	end

	always_comb begin
		rx.ready    = (state_q == ST_HUNT);
		frame.valid = (state_q == ST_SEND);
		frame.frame_address = slots[win_slot_q].address;
		frame.frame_command = slots[win_slot_q].command;
		frame.frame_length  = slots[win_slot_q].length[5:0];
		frame.has_payload   = (n_q != '0);
		frame.payload_byte  = (n_q != '0) ? ram_rdata : 8'd0;
		frame.payload_index = (n_q != '0) ? 5'(i_q) : 5'd0;
		frame.slot_overflow = ovf_q;
		frame.last          = (i_q + 1'b1 >= n_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_HUNT;
			limit_q    <= LIMIT_RESET;
			step_q     <= '0;
			ovf_q      <= 1'b0;
			win_q      <= 1'b0;
			win_slot_q <= '0;
			win_age_q  <= '0;
			n_q        <= '0;
			i_q        <= '0;
		end else begin
			state_q <= state_d;
			if (psel && penable && pwrite && paddr == REG_LENGTH_LIMIT) begin
				limit_q <= pwdata[5:0];
			end
			if (accept_in) begin
				step_q <= '0;
				win_q  <= 1'b0;
				i_q    <= '0;
			end else if (state_q == ST_WAIT) begin
				step_q <= step_q + 1'b1;
			end
			if (age_inc && drop_any) begin
				ovf_q <= 1'b1;
			end
			if (cell_active_step && rpts[cur].win &&
					(!win_q || slots[cur].age < win_age_q)) begin
				win_q      <= 1'b1;
				win_slot_q <= cur;
				win_age_q  <= slots[cur].age;
			end
			if (state_q == ST_WAIT && state_d == ST_SEND) begin
				n_q <= ((slots[win_slot_q].length - HEADER_BYTES) > 8'(PAYLOAD_CAP)) ?
					(PIDX_W+1)'(PAYLOAD_CAP) :
					(PIDX_W+1)'(slots[win_slot_q].length - HEADER_BYTES);
			end
			if (state_q == ST_SEND && out_fire) begin
				i_q <= i_q + 1'b1;
				if (frame.last) begin
					ovf_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			byte_q <= rx.rx_byte;
		end
	end
endmodule
